[rtl/trial_division_prime_test_defines.svh]
// Assertion macros used by the trial division prime test datapath.
`ifndef TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH

`ifndef SYNTH
// Property holds on every clock edge outside reset.
`define TDPT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("tdpt assertion failed");
// Consequent holds in the cycle after the antecedent.
`define TDPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tdpt assertion failed");
`else
`define TDPT_ASSERT(lbl, clk, rst_n, prop)
`define TDPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/tdpt_pkg.sv]
// ----------------------------------------------------------------------------
// tdpt_pkg
// Widths, constants, state and command types of the trial division prime test.
// ----------------------------------------------------------------------------
package tdpt_pkg;

	localparam int VALUE_W = 32;
	localparam int DIV_W   = VALUE_W / 2 + 1;
	localparam int REM_W   = DIV_W + 1;
	localparam int SQ_W    = VALUE_W + 2;
	localparam int CNT_W   = $clog2(VALUE_W);

	localparam int FIRST_DIV = 3;
	localparam int DIV_STEP  = 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLASSIFY,
		ST_CHECK,
		ST_DIVIDE,
		ST_JUDGE,
		ST_FINISH
	} tdpt_state_t;

	typedef struct packed {
		logic load;
		logic rem_start;
		logic rem_step;
		logic div_next;
		logic res_set;
		logic res_val;
		logic out_load;
	} tdpt_cmd_t;

	typedef struct packed {
		logic below_two;
		logic is_two;
		logic is_even;
		logic sq_over;
		logic rem_zero;
		logic cnt_zero;
		logic out_busy;
	} tdpt_stat_t;

endpackage

[rtl/tdpt_ifs.sv]
// ----------------------------------------------------------------------------
// tdpt request and response channels
// Valid/ready channels carrying the value under test and the prime verdict.
// ----------------------------------------------------------------------------
interface tdpt_req_if import tdpt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface tdpt_rsp_if;
	logic valid;
	logic ready;
	logic prime_flag;

	modport source (output valid, output prime_flag, input ready);
	modport sink   (input valid, input prime_flag, output ready);
endinterface

[rtl/trial_division_prime_test.sv]
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Primality test of one unsigned value per request by odd trial division.
// ----------------------------------------------------------------------------
// One request at a time. Values below two and even values are settled by
// classification alone. Odd values run one divisor after another, 3, 5, 7
// and so on, until the square of the divisor passes the value or a remainder
// is zero; each divisor takes a bound check, a remainder over all 32 value
// bits computed one bit per cycle, and a verdict, so a large prime takes up
// to about 32768 divisors. The verdict sits in an output register, and the
// next request is taken while it waits to be read.
// ----------------------------------------------------------------------------
module trial_division_prime_test import tdpt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	tdpt_req_if.sink   req,
	tdpt_rsp_if.source rsp
);

	tdpt_cmd_t  cmd;
	tdpt_stat_t stat;

	tdpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	tdpt_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.value  (req.value),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

[rtl/tdpt_datapath.sv]
// ----------------------------------------------------------------------------
// tdpt_datapath
// Value, divisor and running square registers, bit-serial remainder unit and
// the output register of the verdict.
// ----------------------------------------------------------------------------
`include "trial_division_prime_test_defines.svh"

module tdpt_datapath import tdpt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [VALUE_W-1:0] value,
	input  tdpt_cmd_t          cmd,
	output tdpt_stat_t         stat,
	tdpt_rsp_if.source         rsp
);

	logic [VALUE_W-1:0] value_q;
	logic [DIV_W-1:0]   div_q;
	logic [SQ_W-1:0]    sq_q;
	logic [REM_W-1:0]   rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               res_q;
	logic               out_valid_q;
	logic               out_flag_q;

	logic [REM_W-1:0]   rem_shift;
	logic [REM_W-1:0]   div_ext;

	assign div_ext   = {1'b0, div_q};
	assign rem_shift = {rem_q[DIV_W-1:0], value_q[cnt_q]};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= value;
			div_q   <= DIV_W'(FIRST_DIV);
			sq_q    <= SQ_W'(FIRST_DIV * FIRST_DIV);
		end else if (cmd.div_next) begin
			// (d+2)^2 = d^2 + 4d + 4
			div_q <= div_q + DIV_W'(DIV_STEP);
			sq_q  <= sq_q + (SQ_W'(div_q) << 2) + SQ_W'(4);
		end
		if (cmd.rem_start) begin
			rem_q <= '0;
			cnt_q <= CNT_W'(VALUE_W - 1);
		end else if (cmd.rem_step) begin
			rem_q <= (rem_shift >= div_ext) ? rem_shift - div_ext : rem_shift;
			cnt_q <= cnt_q - CNT_W'(1);
		end
		if (cmd.res_set) begin
			res_q <= cmd.res_val;
		end
		if (cmd.out_load) begin
			out_flag_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.prime_flag = out_flag_q;

	always_comb begin
		stat.below_two = (value_q < VALUE_W'(2));
		stat.is_two    = (value_q == VALUE_W'(2));
		stat.is_even   = ~value_q[0];
		stat.sq_over   = (sq_q > SQ_W'(value_q));
		stat.rem_zero  = (rem_q == '0);
		stat.cnt_zero  = (cnt_q == '0);
		stat.out_busy  = out_valid_q & ~rsp.ready;
	end

	`TDPT_ASSERT_NEXT(a_rem_bound, clk, arst_n, cmd.rem_step, rem_q < div_ext)
	`TDPT_ASSERT_NEXT(a_div_odd, clk, arst_n, cmd.load || cmd.div_next, div_q[0])
	`TDPT_ASSERT_NEXT(a_sq_track, clk, arst_n, cmd.load || cmd.div_next, sq_q == SQ_W'(div_q) * SQ_W'(div_q))
	`TDPT_ASSERT(a_no_overwrite, clk, arst_n, !(cmd.out_load && out_valid_q && !rsp.ready))

endmodule

[rtl/tdpt_ctrl.sv]
// ----------------------------------------------------------------------------
// tdpt_ctrl
// Sequencer: classify the value; if odd and above two, walk odd divisors,
// one remainder per divisor a bit per cycle, until a factor or square bound.
// ----------------------------------------------------------------------------
module tdpt_ctrl import tdpt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  tdpt_stat_t stat,
	output tdpt_cmd_t  cmd
);

	tdpt_state_t state_q;
	tdpt_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) state_nxt = ST_CLASSIFY;
			end
			ST_CLASSIFY: begin
				if (stat.below_two || stat.is_two || stat.is_even) state_nxt = ST_FINISH;
				else state_nxt = ST_CHECK;
			end
			ST_CHECK: begin
				if (stat.sq_over) state_nxt = ST_FINISH;
				else state_nxt = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (stat.cnt_zero) state_nxt = ST_JUDGE;
			end
			ST_JUDGE: begin
				if (stat.rem_zero) state_nxt = ST_FINISH;
				else state_nxt = ST_CHECK;
			end
			ST_FINISH: begin
				if (!stat.out_busy) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			ST_CLASSIFY: begin
				cmd.res_set = 1'b1;
				cmd.res_val = stat.is_two;
			end
			ST_CHECK: begin
				// square past the value: no factor left, so prime
				cmd.res_set   = stat.sq_over;
				cmd.res_val   = 1'b1;
				cmd.rem_start = ~stat.sq_over;
			end
			ST_DIVIDE: begin
				cmd.rem_step = 1'b1;
			end
			ST_JUDGE: begin
				cmd.res_set  = stat.rem_zero;
				cmd.res_val  = 1'b0;
				cmd.div_next = ~stat.rem_zero;
			end
			ST_FINISH: begin
				cmd.out_load = ~stat.out_busy;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule
